// ----- hw/rtl/imh_pkg.sv -----
package imh_pkg;

  localparam int KEY_W = 32;
  localparam int PAY_W = 32;
  localparam int ID_W = 8;
  localparam int STATUS_W = 3;
  localparam int CMD_W = 2;

  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SET_KEY = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DEL_MIN = 2'd2;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FULL = 3'd1;
  localparam logic [STATUS_W-1:0] ST_PRESENT = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd3;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 3'd4;

endpackage

// ----- hw/rtl/imh_if.sv -----
interface imh_req_if import imh_pkg::*; ();
  logic valid;
  logic ready;
  logic [CMD_W-1:0] command;
  logic [ID_W-1:0] item_id;
  logic signed [KEY_W-1:0] key;
  logic [PAY_W-1:0] payload;
  modport source (output valid, command, item_id, key, payload, input ready);
  modport sink (input valid, command, item_id, key, payload, output ready);
endinterface

interface imh_rsp_if import imh_pkg::*; ();
  logic valid;
  logic ready;
  logic [STATUS_W-1:0] status;
  logic [ID_W-1:0] out_id;
  logic signed [KEY_W-1:0] out_key;
  logic [PAY_W-1:0] out_payload;
  modport source (output valid, status, out_id, out_key, out_payload, input ready);
  modport sink (input valid, status, out_id, out_key, out_payload, output ready);
endinterface

// ----- hw/rtl/indexed_min_heap_top.sv -----
// Channel  Direction  Interface   Moves
// req      in         imh_req_if  one command request
// rsp      out        imh_rsp_if  one status / taken entry per request
//
// One request at a time. The position map read is registered (S_LOOK, S_DEC).
// Each sift up level reads the parent, then compares; each sift down level
// reads the left child, then the right child, then compares; taking the root
// reads the root, then the last entry. All of this is set by the single read
// port of the heap memory. The longest request is a remove from the deepest
// slot of a full heap. After reset the position map is cleared entry by entry,
// during which no request is taken. A stalled response holds the block.
module indexed_min_heap_top import imh_pkg::*; #(
  parameter int CAPACITY = 64,
  parameter int ID_COUNT = 256
) (
  input logic clk,
  input logic rst,
  imh_req_if.sink req,
  imh_rsp_if.source rsp
);

  localparam int PW = $clog2(CAPACITY + 1) + 1;  // slot index, 1-based
  localparam int IW = (ID_COUNT > 1) ? $clog2(ID_COUNT) : 1;
  localparam int MW = KEY_W + ID_W + PAY_W;

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_LOOK = 4'd2;
  localparam logic [3:0] S_DEC = 4'd3;
  localparam logic [3:0] S_UP_RD = 4'd4;
  localparam logic [3:0] S_UP_CMP = 4'd5;
  localparam logic [3:0] S_DN_RD = 4'd6;
  localparam logic [3:0] S_DN_RD2 = 4'd7;
  localparam logic [3:0] S_DN_CMP = 4'd8;
  localparam logic [3:0] S_PUT = 4'd9;
  localparam logic [3:0] S_RESP = 4'd10;
  localparam logic [3:0] S_ROOT = 4'd11;
  localparam logic [3:0] S_LAST = 4'd12;
  localparam logic [3:0] S_OLD_RD = 4'd13;
  localparam logic [3:0] S_OLD_CHK = 4'd14;
  localparam logic [3:0] S_LAST_RD = 4'd15;

  // Heap memory {key, id, payload}, slots 1..CAPACITY, and position map.
  logic [MW-1:0] heap_mem [0:(1<<PW)-1];
  logic [PW-1:0] pos_mem [0:ID_COUNT-1];

  logic [3:0] state;
  logic [PW-1:0] fill_count;
  logic [IW:0] clr_idx;

  logic [CMD_W-1:0] cmd;
  logic [ID_W-1:0] id;
  logic signed [KEY_W-1:0] key;
  logic [PAY_W-1:0] pay;
  logic id_ok;

  // Entry being placed, and its current slot.
  logic signed [KEY_W-1:0] m_key;
  logic [ID_W-1:0] m_id;
  logic [PAY_W-1:0] m_pay;
  logic [PW-1:0] p;
  logic remove_mode;   // remove: shift all ancestors down, no compare
  logic take_after;    // after placing, take the root
  logic [PW-1:0] last;
  logic signed [KEY_W-1:0] left_key;
  logic [MW-1:0] left_ent;

  logic [STATUS_W-1:0] st;
  logic [ID_W-1:0] o_id;
  logic [KEY_W-1:0] o_key;
  logic [PAY_W-1:0] o_pay;

  // Memory ports.
  logic [PW-1:0] h_raddr;
  logic [MW-1:0] h_rdata;
  logic h_we;
  logic [PW-1:0] h_waddr;
  logic [MW-1:0] h_wdata;
  logic [IW-1:0] p_raddr;
  logic [PW-1:0] p_rdata;
  logic p_we;
  logic [IW-1:0] p_waddr;
  logic [PW-1:0] p_wdata;

  always_ff @(posedge clk) begin
    if (h_we) heap_mem[h_waddr] <= h_wdata;
    h_rdata <= heap_mem[h_raddr];
    if (p_we) pos_mem[p_waddr] <= p_wdata;
    p_rdata <= pos_mem[p_raddr];
  end

  logic signed [KEY_W-1:0] rd_key;
  logic [ID_W-1:0] rd_id;
  assign rd_key = h_rdata[MW-1 -: KEY_W];
  assign rd_id = h_rdata[PAY_W +: ID_W];
  assign id_ok = ({{(32-ID_W){1'b0}}, id} < ID_COUNT);

  // Child slots of p and the sift decisions taken on the read data.
  logic [PW-1:0] child_l;
  logic [PW-1:0] child_r;
  logic up_move;
  logic dn_has_left;
  logic dn_right_sel;
  logic dn_move_right;
  logic dn_move_left;
  assign child_l = p << 1;
  assign child_r = child_l + 1'b1;
  assign up_move = (p > PW'(1)) && (remove_mode || (m_key < rd_key));
  assign dn_has_left = (child_l <= fill_count);
  assign dn_right_sel = (child_l < fill_count) && (rd_key < left_key);
  assign dn_move_right = dn_has_left && dn_right_sel && (rd_key < m_key);
  assign dn_move_left = dn_has_left && !dn_right_sel && (left_key < m_key);

  assign req.ready = (state == S_IDLE);
  assign rsp.valid = (state == S_RESP);
  assign rsp.status = st;
  assign rsp.out_id = o_id;
  assign rsp.out_key = o_key;
  assign rsp.out_payload = o_pay;

  // Memory address and write control per state.
  always_comb begin
    h_raddr = p;
    h_we = 1'b0;
    h_waddr = p;
    h_wdata = h_rdata;
    p_raddr = id[IW-1:0];
    p_we = 1'b0;
    p_waddr = rd_id[IW-1:0];
    p_wdata = p;
    case (state)
      S_CLEAR: begin
        p_we = 1'b1;
        p_waddr = clr_idx[IW-1:0];
        p_wdata = '0;
      end
      S_IDLE: p_raddr = req.item_id[IW-1:0];
      S_UP_RD: h_raddr = p >> 1;
      S_UP_CMP: begin
        // Parent moves down into slot p.
        if (up_move) begin
          h_we = 1'b1;
          p_we = 1'b1;
        end
      end
      S_DN_RD: h_raddr = child_l;
      S_DN_RD2: h_raddr = child_r;
      S_DN_CMP: begin
        // The chosen child moves up into slot p.
        if (dn_move_right) begin
          h_we = 1'b1;
          p_we = 1'b1;
        end else if (dn_move_left) begin
          h_we = 1'b1;
          h_wdata = left_ent;
          p_we = 1'b1;
          p_waddr = left_ent[PAY_W +: IW];
        end
      end
      S_PUT: begin
        h_we = 1'b1;
        h_wdata = {m_key, m_id, m_pay};
        p_we = 1'b1;
        p_waddr = m_id[IW-1:0];
      end
      S_ROOT: begin
        h_raddr = PW'(1);
        p_raddr = id[IW-1:0];
      end
      S_LAST: begin
        h_raddr = last;
        // Clear the taken root id in the map.
        p_we = 1'b1;
        p_waddr = rd_id[IW-1:0];
        p_wdata = '0;
      end
      default: ;
    endcase
  end

  // Request sequencing.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      fill_count <= '0;
      clr_idx <= '0;
    end else begin
      case (state)
        S_CLEAR: begin
          clr_idx <= clr_idx + 1'b1;
          if (clr_idx == (IW+1)'(ID_COUNT - 1)) state <= S_IDLE;
        end
        S_IDLE: if (req.valid) begin
          cmd <= req.command;
          id <= req.item_id;
          key <= req.key;
          pay <= req.payload;
          st <= ST_OK;
          o_id <= '0;
          o_key <= '0;
          o_pay <= '0;
          remove_mode <= 1'b0;
          take_after <= 1'b0;
          state <= S_LOOK;
        end
        S_LOOK: state <= S_DEC;  // map read data lands
        S_DEC: begin
          p <= p_rdata;
          m_id <= id;
          case (cmd)
            CMD_INSERT: begin
              if (fill_count >= PW'(CAPACITY)) begin
                st <= ST_FULL; state <= S_RESP;
              end else if (!id_ok) begin
                st <= ST_NOT_FOUND; state <= S_RESP;
              end else if (p_rdata != '0) begin
                st <= ST_PRESENT; state <= S_RESP;
              end else begin
                fill_count <= fill_count + 1'b1;
                p <= fill_count + 1'b1;
                m_key <= key;
                m_pay <= pay;
                state <= S_UP_RD;
              end
            end
            CMD_DEL_MIN: begin
              if (fill_count == '0) begin
                st <= ST_EMPTY; state <= S_RESP;
              end else state <= S_ROOT;
            end
            default: begin
              if (!id_ok || p_rdata == '0) begin
                st <= ST_NOT_FOUND; state <= S_RESP;
              end else state <= S_OLD_RD;
            end
          endcase
        end
        // The entry at slot p is read here and checked in the cycle after.
        S_OLD_RD: state <= S_OLD_CHK;
        S_OLD_CHK: begin
          m_pay <= h_rdata[PAY_W-1:0];
          if (cmd == CMD_REMOVE) begin
            o_key <= rd_key;
            o_pay <= h_rdata[PAY_W-1:0];
            m_key <= rd_key;
            remove_mode <= 1'b1;
            take_after <= 1'b1;
            state <= S_UP_RD;
          end else begin
            m_key <= key;
            if (rd_key > key) state <= S_UP_RD;
            else if (rd_key < key) state <= S_DN_RD;
            else begin
              // Equal key: the heap stays as it is.
              state <= S_RESP;
            end
          end
        end
        S_UP_RD: state <= S_UP_CMP;
        S_UP_CMP: begin
          if (up_move) begin
            p <= p >> 1;
            state <= S_UP_RD;
          end else state <= S_PUT;
        end
        S_DN_RD: state <= S_DN_RD2;
        S_DN_RD2: begin
          left_key <= rd_key;
          left_ent <= h_rdata;
          state <= S_DN_CMP;
        end
        S_DN_CMP: begin
          if (dn_move_right) begin
            p <= child_r;
            state <= S_DN_RD;
          end else if (dn_move_left) begin
            p <= child_l;
            state <= S_DN_RD;
          end else state <= S_PUT;
        end
        S_PUT: begin
          if (take_after) begin
            take_after <= 1'b0;
            state <= S_ROOT;
          end else state <= S_RESP;
        end
        S_ROOT: state <= S_LAST;
        S_LAST: begin
          // Root entry on the read port now.
          if (cmd == CMD_DEL_MIN) begin
            o_id <= rd_id;
            o_key <= rd_key;
            o_pay <= h_rdata[PAY_W-1:0];
          end
          fill_count <= fill_count - 1'b1;
          state <= S_LAST_RD;
        end
        S_LAST_RD: begin
          // Last entry read; sift it down from the root.
          m_key <= rd_key;
          m_id <= rd_id;
          m_pay <= h_rdata[PAY_W-1:0];
          p <= PW'(1);
          remove_mode <= 1'b0;
          state <= (fill_count == '0) ? S_RESP : S_DN_RD;
        end
        S_RESP: if (rsp.ready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  // The last occupied slot, read when the root is taken.
  assign last = fill_count;

endmodule

// ----- tb/tb.sv -----
module tb;
  import imh_pkg::*;

  localparam int HEAP_DEPTH = 64;
  localparam int ID_RANGE = 256;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int RANDOM_ITEMS = 1070;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ID_W-1:0] out_id;
    logic signed [KEY_W-1:0] out_key;
    logic [PAY_W-1:0] out_payload;
  } heap_answer_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  imh_req_if req ();
  imh_rsp_if rsp ();

  indexed_min_heap_top #(.CAPACITY(HEAP_DEPTH), .ID_COUNT(ID_RANGE)) i_dut (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rsp(rsp)
  );

  always #5 clk = ~clk;

  // Shadow copy of the heap, kept in step with every accepted request.
  logic signed [KEY_W-1:0] shadow_key [1:HEAP_DEPTH];
  logic [ID_W-1:0] shadow_id [1:HEAP_DEPTH];
  logic [PAY_W-1:0] shadow_pay [1:HEAP_DEPTH];
  int slot_of_id [ID_RANGE];
  int heap_fill;

  heap_answer_t pending_answers [$];
  int mismatch_count = 0;
  int answers_seen = 0;
  int requests_sent = 0;
  int cycle_count = 0;
  int hold_request = 0;
  int hold_done = 0;
  int stall_left = 0;
  bit rsp_no_stall = 1'b0;
  bit req_no_gap = 1'b0;
  int status_hits [8];

  function automatic void put_slot(int p, logic signed [KEY_W-1:0] k, logic [ID_W-1:0] id,
                                   logic [PAY_W-1:0] pay);
    shadow_key[p] = k;
    shadow_id[p] = id;
    shadow_pay[p] = pay;
    slot_of_id[id] = p;
  endfunction

  function automatic void move_slot(int dst, int src);
    put_slot(dst, shadow_key[src], shadow_id[src], shadow_pay[src]);
  endfunction

  function automatic void sift_up(int p, logic signed [KEY_W-1:0] k, logic [ID_W-1:0] id,
                                  logic [PAY_W-1:0] pay);
    while (p > 1 && k < shadow_key[p/2]) begin
      move_slot(p, p/2);
      p = p / 2;
    end
    put_slot(p, k, id, pay);
  endfunction

  function automatic void sift_down(int p, logic signed [KEY_W-1:0] k, logic [ID_W-1:0] id,
                                    logic [PAY_W-1:0] pay);
    int c;
    while (p * 2 <= heap_fill) begin
      c = p * 2;
      // The right child wins only when strictly smaller.
      if (c < heap_fill && shadow_key[c+1] < shadow_key[c]) c++;
      if (shadow_key[c] < k) begin
        move_slot(p, c);
        p = c;
      end else begin
        break;
      end
    end
    put_slot(p, k, id, pay);
  endfunction

  function automatic void take_root();
    int last;
    last = heap_fill;
    slot_of_id[shadow_id[1]] = 0;
    heap_fill--;
    if (heap_fill > 0) sift_down(1, shadow_key[last], shadow_id[last], shadow_pay[last]);
  endfunction

  // Applies one request to the shadow heap and returns the answer it should give.
  function automatic heap_answer_t heap_predict(logic [CMD_W-1:0] cmd, logic [ID_W-1:0] id,
                                                logic signed [KEY_W-1:0] k,
                                                logic [PAY_W-1:0] pay);
    heap_answer_t a;
    int p;
    logic signed [KEY_W-1:0] old_key;
    logic [PAY_W-1:0] old_pay;
    a = '0;
    a.status = ST_OK;
    p = slot_of_id[id];
    case (cmd)
      CMD_INSERT: begin
        if (heap_fill >= HEAP_DEPTH) a.status = ST_FULL;
        else if (p != 0) a.status = ST_PRESENT;
        else begin
          heap_fill++;
          sift_up(heap_fill, k, id, pay);
        end
      end
      CMD_SET_KEY: begin
        if (p == 0) a.status = ST_NOT_FOUND;
        else begin
          old_key = shadow_key[p];
          old_pay = shadow_pay[p];
          shadow_key[p] = k;
          if (old_key > k) sift_up(p, k, id, old_pay);
          else if (old_key < k) sift_down(p, k, id, old_pay);
        end
      end
      CMD_DEL_MIN: begin
        if (heap_fill == 0) a.status = ST_EMPTY;
        else begin
          a.out_id = shadow_id[1];
          a.out_key = shadow_key[1];
          a.out_payload = shadow_pay[1];
          take_root();
        end
      end
      default: begin
        if (p == 0) a.status = ST_NOT_FOUND;
        else begin
          old_key = shadow_key[p];
          old_pay = shadow_pay[p];
          a.out_key = old_key;
          a.out_payload = old_pay;
          // Pull the entry up to the root, shifting its ancestors down.
          while (p > 1) begin
            move_slot(p, p/2);
            p = p / 2;
          end
          put_slot(1, old_key, id, old_pay);
          take_root();
        end
      end
    endcase
    return a;
  endfunction

  task automatic report(string field, longint got, longint want);
    $display("ERROR answer %0d: %s got %0d expected %0d", answers_seen, field, got, want);
    mismatch_count++;
  endtask

  // Sends one request after a random gap (none while req_no_gap is set) and records its answer once accepted.
  task automatic send_request(logic [CMD_W-1:0] cmd, logic [ID_W-1:0] id,
                              logic signed [KEY_W-1:0] k, logic [PAY_W-1:0] pay);
    int gap;
    int r;
    bit rdy;
    r = $urandom_range(0, 99);
    if (req_no_gap || r < 60) gap = 0;
    else if (r < 95) gap = $urandom_range(1, 3);
    else gap = $urandom_range(10, 40);
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req.valid <= 1'b1;
    req.command <= cmd;
    req.item_id <= id;
    req.key <= k;
    req.payload <= pay;
    forever begin
      @(negedge clk);
      rdy = req.ready;
      @(posedge clk);
      if (rdy) break;
    end
    pending_answers.push_back(heap_predict(cmd, id, k, pay));
    status_hits[pending_answers[$].status]++;
    requests_sent++;
  endtask

  task automatic wait_drained();
    req.valid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
  endtask

  function automatic logic signed [KEY_W-1:0] pick_key();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return $urandom();
    if (r < 8) return $signed($urandom_range(0, 15)) - 8;
    if (r == 8) return 32'sh8000_0000;
    return 32'sh7fff_ffff;
  endfunction

  function automatic logic [ID_W-1:0] pick_id(bit want_present);
    if (want_present && heap_fill > 0 && $urandom_range(0, 9) < 7)
      return shadow_id[$urandom_range(1, heap_fill)];
    if ($urandom_range(0, 9) < 8) return ID_W'($urandom_range(0, 47));
    return ID_W'($urandom_range(0, ID_RANGE - 1));
  endfunction

  // Receiver side: random short and long stalls (none while rsp_no_stall is set), or a commanded long hold-off.
  always @(posedge clk) begin
    if (rst) begin
      rsp.ready <= 1'b0;
    end else if (hold_done < hold_request) begin
      rsp.ready <= 1'b0;
      hold_done <= hold_done + 1;
    end else if (rsp_no_stall) begin
      rsp.ready <= 1'b1;
    end else if (stall_left > 0) begin
      rsp.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      rsp.ready <= 1'b1;
      if ($urandom_range(0, 99) < 20)
        stall_left <= ($urandom_range(0, 19) == 0) ? $urandom_range(15, 50) : $urandom_range(1, 3);
    end
  end

  // Answer checker: the handshake seen here completes at the next rising edge.
  always @(negedge clk) begin
    heap_answer_t want;
    if (!rst && rsp.valid && rsp.ready) begin
      answers_seen++;
      if (pending_answers.size() == 0) begin
        $display("ERROR answer %0d arrived with nothing pending", answers_seen);
        mismatch_count++;
      end else begin
        want = pending_answers.pop_front();
        if (rsp.status !== want.status) report("status", rsp.status, want.status);
        if (rsp.out_id !== want.out_id) report("out_id", rsp.out_id, want.out_id);
        if (rsp.out_key !== want.out_key) report("out_key", rsp.out_key, want.out_key);
        if (rsp.out_payload !== want.out_payload)
          report("out_payload", rsp.out_payload, want.out_payload);
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Mismatches found");
      $finish;
    end
  end

  // Error answers on an empty heap, both extremes of every field, and the
  // equal, smaller and larger cases of set key, plus a repeated insert and a repeated remove.
  task automatic test_directed();
    send_request(CMD_DEL_MIN, 8'd0, '0, '0);
    send_request(CMD_REMOVE, 8'd5, '0, '0);
    send_request(CMD_SET_KEY, 8'd5, 32'sd1, '0);
    send_request(CMD_INSERT, 8'd0, 32'sh8000_0000, 32'hffff_ffff);
    send_request(CMD_INSERT, 8'd255, 32'sh7fff_ffff, 32'h0);
    send_request(CMD_INSERT, 8'd0, 32'sd3, 32'h1234);
    send_request(CMD_INSERT, 8'd10, 32'sd5, 32'haaaa_5555);
    send_request(CMD_INSERT, 8'd11, 32'sd5, 32'h5555_aaaa);
    send_request(CMD_INSERT, 8'd12, -32'sd7, 32'h0f0f_0f0f);
    send_request(CMD_SET_KEY, 8'd10, 32'sd5, 32'hdead);
    send_request(CMD_SET_KEY, 8'd255, -32'sd100, '0);
    send_request(CMD_SET_KEY, 8'd0, 32'sh7fff_fffe, '0);
    send_request(CMD_REMOVE, 8'd11, '0, '0);
    send_request(CMD_REMOVE, 8'd11, '0, '0);
    send_request(CMD_REMOVE, 8'd255, '0, '0);
    send_request(CMD_DEL_MIN, 8'd0, '0, '0);
    send_request(CMD_DEL_MIN, 8'd0, '0, '0);
    send_request(CMD_DEL_MIN, 8'd0, '0, '0);
    send_request(CMD_DEL_MIN, 8'd0, '0, '0);
    wait_drained();
  endtask

  // Fill to capacity, try twice more, then empty it again.
  task automatic test_full_heap();
    for (int i = 0; i < HEAP_DEPTH; i++)
      send_request(CMD_INSERT, 8'(i * 3 + 1), pick_key(), $urandom());
    send_request(CMD_INSERT, 8'd200, 32'sd0, 32'h1);
    send_request(CMD_INSERT, 8'd1, 32'sd0, 32'h1);
    for (int i = 0; i < HEAP_DEPTH + 1; i++) send_request(CMD_DEL_MIN, 8'd0, '0, '0);
    wait_drained();
  endtask

  // Random command mix, weighted so the heap wanders between empty and full.
  task automatic test_random_mix();
    int r;
    int insert_share;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 250 == 0) begin
        rsp_no_stall = $urandom_range(0, 2) == 0;
        req_no_gap = $urandom_range(0, 2) == 0;
      end
      insert_share = (heap_fill > 56) ? 30 : 45;
      r = $urandom_range(0, 99);
      if (r < insert_share)
        send_request(CMD_INSERT, pick_id(1'b0), pick_key(), $urandom());
      else if (r < insert_share + 20)
        send_request(CMD_SET_KEY, pick_id(1'b1), pick_key(), $urandom());
      else if (r < insert_share + 38)
        send_request(CMD_DEL_MIN, ID_W'($urandom()), $urandom(), $urandom());
      else
        send_request(CMD_REMOVE, pick_id(1'b1), $urandom(), $urandom());
    end
    rsp_no_stall = 1'b0;
    req_no_gap = 1'b0;
    wait_drained();
  endtask

  // The receiver holds off for a long stretch while requests keep coming.
  task automatic test_backpressure();
    hold_request = hold_done + 400;
    req_no_gap = 1'b1;
    for (int i = 0; i < 30; i++)
      send_request(($urandom_range(0, 1) == 0) ? CMD_INSERT : CMD_DEL_MIN,
                   pick_id(1'b0), pick_key(), $urandom());
    req_no_gap = 1'b0;
    wait_drained();
  endtask

  initial begin
    req.valid = 1'b0;
    req.command = CMD_INSERT;
    req.item_id = '0;
    req.key = '0;
    req.payload = '0;
    heap_fill = 0;
    foreach (slot_of_id[i]) slot_of_id[i] = 0;
    foreach (status_hits[i]) status_hits[i] = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_full_heap();
    test_random_mix();
    test_backpressure();

    repeat (100) @(posedge clk);
    $display("Ran %0d requests, %0d answers checked (ok %0d, full %0d, present %0d,",
             requests_sent, answers_seen, status_hits[ST_OK], status_hits[ST_FULL],
             status_hits[ST_PRESENT]);
    $display("  not found %0d, empty %0d), with random stalls and a long receiver hold-off.",
             status_hits[ST_NOT_FOUND], status_hits[ST_EMPTY]);
    if (mismatch_count == 0 && pending_answers.size() == 0) begin
      $display("No mismatches found");
    end else begin
      if (pending_answers.size() != 0)
        $display("ERROR %0d answers never arrived", pending_answers.size());
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
